// ----- hw/rtl/clkey_pkg.sv -----
package clkey_pkg;

	// Magnitude width of the constant term; also the divider length
	localparam int unsigned MAG_W     = 14;
	localparam int unsigned SHIFT_W   = $clog2(MAG_W);
	localparam int unsigned DIV_STEPS = MAG_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	localparam int unsigned KEY_A_OFF  = 200;
	localparam int unsigned KEY_B_OFF  = 200;
	localparam int unsigned KEY_C_OFF  = 20000;
	localparam int unsigned KEY_B_SPAN = 400;
	localparam int unsigned KEY_C_SPAN = 40000;

	typedef struct packed {
		logic load;
		logic setup;
		logic init1;
		logic init2;
		logic gcd_step;
		logic div_init;
		logic div_step;
		logic key1;
		logic key2;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic gcd_done;
	} sts_t;

endpackage

// ----- hw/rtl/clkey_ctrl.sv -----
module clkey_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  clkey_pkg::sts_t   sts,
	output clkey_pkg::cmd_t   cmd,
	output logic              busy,
	output logic              done
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SETUP = 9'b000000010,
		ST_INIT1 = 9'b000000100,
		ST_GCD1  = 9'b000001000,
		ST_GCD2  = 9'b000010000,
		ST_DIV   = 9'b000100000,
		ST_KEY1  = 9'b001000000,
		ST_KEY2  = 9'b010000000,
		ST_KEY3  = 9'b100000000
	} state_t;

	state_t                       state_q, state_d;
	logic [clkey_pkg::CNT_W-1:0]  cnt_q;
	logic                         done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_INIT1;
			end
			ST_INIT1: begin
				cmd.init1 = 1'b1;
				state_d   = ST_GCD1;
			end
			ST_GCD1: begin
				if (sts.gcd_done) begin
					cmd.init2 = 1'b1;
					state_d   = ST_GCD2;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_GCD2: begin
				if (sts.gcd_done) begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end else begin
					cmd.gcd_step = 1'b1;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == clkey_pkg::CNT_W'(clkey_pkg::DIV_STEPS - 1)) begin
					state_d = ST_KEY1;
				end
			end
			ST_KEY1: begin
				cmd.key1 = 1'b1;
				state_d  = ST_KEY2;
			end
			ST_KEY2: begin
				cmd.key2 = 1'b1;
				state_d  = ST_KEY3;
			end
			ST_KEY3: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe lasted more than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done_q))
		else $error("accepted transfer did not make the block busy");

endmodule

// ----- hw/rtl/clkey_dp.sv -----
module clkey_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  clkey_pkg::cmd_t      cmd,
	output clkey_pkg::sts_t      sts,
	input  logic [6:0]           first_x,
	input  logic [6:0]           first_y,
	input  logic [6:0]           second_x,
	input  logic [6:0]           second_y,
	output logic [6:0]           coef_a,
	output logic signed [7:0]    coef_b,
	output logic signed [14:0]   coef_c,
	output logic [32:0]          line_key,
	output logic                 same_point
);

	localparam int unsigned W = clkey_pkg::MAG_W;

	logic [6:0]                       px_q, py_q, qx_q, qy_q;
	logic [13:0]                      p1_q, p2_q;
	logic signed [7:0]                a_q, b_q;
	logic [6:0]                       mag_a_q, mag_b_q;
	logic [W-1:0]                     mag_c_q;
	logic                             sgn_b_q, sgn_c_q, same_q;
	logic [W-1:0]                     u_q, v_q, g_q;
	logic [clkey_pkg::SHIFT_W-1:0]    k_q;
	logic [W-1:0]                     rem_q [3];
	logic [W-1:0]                     quo_q [3];
	logic [6:0]                       fa_q;
	logic signed [7:0]                fb_q;
	logic signed [14:0]               fc_q;
	logic [17:0]                      hi_q;
	logic [15:0]                      lo_q;
	logic [6:0]                       coef_a_q;
	logic signed [7:0]                coef_b_q;
	logic signed [14:0]               coef_c_q;
	logic [32:0]                      key_q;
	logic                             same_out_q;

	logic signed [14:0]               c_w;
	logic [W-1:0]                     mag_c_w;
	logic [6:0]                       mag_a_w, mag_b_w;
	logic                             flip_w;
	logic [W-1:0]                     u_d, v_d, gcd_w;
	logic [clkey_pkg::SHIFT_W-1:0]    k_d;
	logic [W:0]                       shl_w  [3];
	logic                             ge_w   [3];
	logic [W-1:0]                     rem_d  [3];
	logic [W-1:0]                     qa_w, qb_w, qc_w;
	logic [9:0]                       b_off_w;
	logic [16:0]                      c_off_w;
	logic [33:0]                      key_w;

	assign sts.gcd_done = (u_q == '0) || (v_q == '0);

	// One of u, v is zero at the end of a gcd pass; the other holds the odd part
	assign gcd_w = W'((u_q | v_q) << k_q);

	always_comb begin
		c_w     = 15'(p1_q) - 15'(p2_q);
		mag_c_w = c_w[14] ? W'(-c_w) : W'(c_w);
		mag_a_w = a_q[7] ? 7'(-a_q) : a_q[6:0];
		mag_b_w = b_q[7] ? 7'(-b_q) : b_q[6:0];
		flip_w  = a_q[7] || ((a_q == '0) && b_q[7]) ||
			((a_q == '0) && (b_q == '0) && c_w[14]);
	end

	// Binary gcd step
	always_comb begin
		u_d = u_q;
		v_d = v_q;
		k_d = k_q;
		priority if (!u_q[0] && !v_q[0]) begin
			u_d = u_q >> 1;
			v_d = v_q >> 1;
			k_d = k_q + 1'b1;
		end else if (!u_q[0]) begin
			u_d = u_q >> 1;
		end else if (!v_q[0]) begin
			v_d = v_q >> 1;
		end else if (u_q >= v_q) begin
			u_d = (u_q - v_q) >> 1;
		end else begin
			v_d = (v_q - u_q) >> 1;
		end
	end

	// Restoring division, three lanes sharing the divisor
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			shl_w[i] = {rem_q[i], quo_q[i][W-1]};
			ge_w[i]  = shl_w[i] >= {1'b0, g_q};
			rem_d[i] = ge_w[i] ? W'(shl_w[i] - {1'b0, g_q}) : shl_w[i][W-1:0];
		end
	end

	always_comb begin
		qa_w    = same_q ? '0 : quo_q[0];
		qb_w    = same_q ? '0 : quo_q[1];
		qc_w    = same_q ? '0 : quo_q[2];
		b_off_w = {{2{fb_q[7]}}, fb_q} + 10'(clkey_pkg::KEY_B_OFF);
		c_off_w = {{2{fc_q[14]}}, fc_q} + 17'(clkey_pkg::KEY_C_OFF);
		key_w   = 34'(hi_q) * 34'(clkey_pkg::KEY_C_SPAN) + 34'(lo_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= first_x;
			py_q <= first_y;
			qx_q <= second_x;
			qy_q <= second_y;
		end
		if (cmd.setup) begin
			p1_q <= 14'(qy_q) * 14'(px_q);
			p2_q <= 14'(qx_q) * 14'(py_q);
			a_q  <= 8'(py_q) - 8'(qy_q);
			b_q  <= 8'(qx_q) - 8'(px_q);
		end
		if (cmd.init1) begin
			mag_a_q <= mag_a_w;
			mag_b_q <= mag_b_w;
			mag_c_q <= mag_c_w;
			sgn_b_q <= b_q[7] ^ flip_w;
			sgn_c_q <= c_w[14] ^ flip_w;
			same_q  <= (a_q == '0) && (b_q == '0);
			u_q     <= W'(mag_a_w);
			v_q     <= W'(mag_b_w);
			k_q     <= '0;
		end else if (cmd.init2) begin
			u_q <= gcd_w;
			v_q <= mag_c_q;
			k_q <= '0;
		end else if (cmd.gcd_step) begin
			u_q <= u_d;
			v_q <= v_d;
			k_q <= k_d;
		end
		if (cmd.div_init) begin
			g_q      <= gcd_w;
			quo_q[0] <= W'(mag_a_q);
			quo_q[1] <= W'(mag_b_q);
			quo_q[2] <= mag_c_q;
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= '0;
			end
		end else if (cmd.div_step) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= rem_d[i];
				quo_q[i] <= {quo_q[i][W-2:0], ge_w[i]};
			end
		end
		if (cmd.key1) begin
			fa_q <= qa_w[6:0];
			fb_q <= sgn_b_q ? 8'(-{1'b0, qb_w[6:0]}) : 8'({1'b0, qb_w[6:0]});
			fc_q <= sgn_c_q ? 15'(-{1'b0, qc_w}) : 15'({1'b0, qc_w});
		end
		if (cmd.key2) begin
			hi_q <= (18'(fa_q) + 18'(clkey_pkg::KEY_A_OFF)) * 18'(clkey_pkg::KEY_B_SPAN)
				+ 18'(b_off_w);
			lo_q <= c_off_w[15:0];
		end
		if (cmd.finish) begin
			coef_a_q   <= fa_q;
			coef_b_q   <= fb_q;
			coef_c_q   <= fc_q;
			key_q      <= key_w[32:0];
			same_out_q <= same_q;
		end
	end

	assign coef_a     = coef_a_q;
	assign coef_b     = coef_b_q;
	assign coef_c     = coef_c_q;
	assign line_key   = key_q;
	assign same_point = same_out_q;

	a_gcd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |=> ((g_q == '0) == same_q))
		else $error("zero gcd does not match coincident points");

	a_same_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (!same_out_q ||
			(coef_a_q == '0 && coef_b_q == '0 && coef_c_q == '0)))
		else $error("coincident points gave nonzero coefficients");

	a_sign_rule: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (coef_a_q != '0 || !coef_b_q[7]))
		else $error("line sign not normalized");

endmodule

// ----- hw/rtl/canonical_line_key.sv -----
// Canonical line through two lattice points: a*x+b*y+c=0 reduced by the gcd of
// |a|,|b|,|c| with a>0, or a==0 and b>0, or both zero and c>=0, plus a packed
// key. Pulse start while busy is low to transfer the four coordinates; busy
// stays high until the result. The result appears on the output ports for one
// cycle with done high and must be taken then: nothing holds it. Done rises
// after the start transfer once setup, the two binary-gcd passes (one shift or
// subtract per cycle; first on |a| and |b|, then on that gcd and |c|), the
// shared divider that reduces |a|, |b| and |c| by the gcd, and the key steps
// are through. A new start is taken in the done cycle. Coincident points give
// zero coefficients and same_point high.
module canonical_line_key (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [6:0]          first_x,
	input  logic [6:0]          first_y,
	input  logic [6:0]          second_x,
	input  logic [6:0]          second_y,
	output logic                done,
	output logic [6:0]          coef_a,
	output logic signed [7:0]   coef_b,
	output logic signed [14:0]  coef_c,
	output logic [32:0]         line_key,
	output logic                same_point
);

	clkey_pkg::cmd_t cmd;
	clkey_pkg::sts_t sts;

	clkey_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	clkey_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.first_x    (first_x),
		.first_y    (first_y),
		.second_x   (second_x),
		.second_y   (second_y),
		.coef_a     (coef_a),
		.coef_b     (coef_b),
		.coef_c     (coef_c),
		.line_key   (line_key),
		.same_point (same_point)
	);

endmodule
